// ----- hw/rtl/nrsp_pkg.sv -----
// Shared types and constants for the note record stream parser.
// Used by the front, back and top level; depends on nothing else.
`default_nettype none

package nrsp_pkg;

  // Defaults handed to the top level parameters
  localparam int TICK_BITS_DEFAULT   = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Fixed field widths of a result record
  localparam int TICK_OUT_W = 24;
  localparam int LAYER_W    = 16;

  localparam logic [7:0] VERSION_RESET    = 8'd4;
  localparam logic [7:0] VERSION_EXT_MIN  = 8'd4;
  localparam logic [7:0] VELOCITY_DEFAULT = 8'd100;
  localparam logic [8:0] PAN_BIAS         = 9'd100;

  localparam logic RECORD_NOTE = 1'b0;
  localparam logic RECORD_END  = 1'b1;

  // Commands passed from the front to the back
  localparam logic [3:0] CMD_END       = 4'd0;
  localparam logic [3:0] CMD_TICK      = 4'd1;
  localparam logic [3:0] CMD_LAYER_CLR = 4'd2;
  localparam logic [3:0] CMD_LAYER     = 4'd3;
  localparam logic [3:0] CMD_INSTR     = 4'd4;
  localparam logic [3:0] CMD_KEY_SHORT = 4'd5;
  localparam logic [3:0] CMD_KEY_LONG  = 4'd6;
  localparam logic [3:0] CMD_VEL       = 4'd7;
  localparam logic [3:0] CMD_PAN       = 4'd8;
  localparam logic [3:0] CMD_PITCH     = 4'd9;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic                   kind;
    logic [TICK_OUT_W-1:0]  tick;
    logic [LAYER_W-1:0]     layer;
    logic [7:0]             instrument;
    logic [7:0]             note_key;
    logic [7:0]             velocity;
    logic signed [8:0]      panning;
    logic signed [15:0]     pitch;
  } rec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nrsp_fifo.sv -----
// Small register-based queue used between the parser stages and at the output.
// Standalone; depth must be at least 2.
`default_nettype none

module nrsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nrsp_front.sv -----
// Front stage: byte sequencer that tracks the stream layout and issues commands.
// Depends on nrsp_pkg; holds the format version register.
`default_nettype none

module nrsp_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_format_version,
  output logic             cmd_push,
  output nrsp_pkg::cmd_t   cmd,
  input  wire logic        cmd_full
);
  import nrsp_pkg::*;

  localparam logic [3:0] PH_TICK_LO  = 4'd0;
  localparam logic [3:0] PH_TICK_HI  = 4'd1;
  localparam logic [3:0] PH_LAYER_LO = 4'd2;
  localparam logic [3:0] PH_LAYER_HI = 4'd3;
  localparam logic [3:0] PH_INSTR    = 4'd4;
  localparam logic [3:0] PH_KEY      = 4'd5;
  localparam logic [3:0] PH_VEL      = 4'd6;
  localparam logic [3:0] PH_PAN      = 4'd7;
  localparam logic [3:0] PH_PITCH_LO = 4'd8;
  localparam logic [3:0] PH_PITCH_HI = 4'd9;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  version_r;
  logic        accept;
  logic        issue;
  logic [15:0] word;

  assign in_full   = cmd_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !cmd_full;
  assign word      = {in_data_byte, low_r};
  assign cmd_push  = accept && issue;

  always_comb begin
    phase_nxt = phase_r;
    low_nxt   = low_r;
    issue     = 1'b0;
    cmd.op    = CMD_INSTR;
    cmd.data  = {8'h00, in_data_byte};
    case (phase_r)
      PH_TICK_HI: begin
        issue = 1'b1;
        cmd.data = word;
        if (word == 16'h0000) begin
          cmd.op    = CMD_END;
          phase_nxt = PH_TICK_LO;
        end else begin
          cmd.op    = CMD_TICK;
          phase_nxt = PH_LAYER_LO;
        end
      end
      PH_LAYER_LO: begin
        low_nxt   = in_data_byte;
        phase_nxt = PH_LAYER_HI;
      end
      PH_LAYER_HI: begin
        issue = 1'b1;
        cmd.data = word;
        if (word == 16'h0000) begin
          cmd.op    = CMD_LAYER_CLR;
          phase_nxt = PH_TICK_LO;
        end else begin
          cmd.op    = CMD_LAYER;
          phase_nxt = PH_INSTR;
        end
      end
      PH_INSTR: begin
        issue     = 1'b1;
        cmd.op    = CMD_INSTR;
        phase_nxt = PH_KEY;
      end
      PH_KEY: begin
        issue = 1'b1;
        // sample the version here: it decides whether the optional bytes follow
        if (version_r >= VERSION_EXT_MIN) begin
          cmd.op    = CMD_KEY_LONG;
          phase_nxt = PH_VEL;
        end else begin
          cmd.op    = CMD_KEY_SHORT;
          phase_nxt = PH_LAYER_LO;
        end
      end
      PH_VEL: begin
        issue     = 1'b1;
        cmd.op    = CMD_VEL;
        phase_nxt = PH_PAN;
      end
      PH_PAN: begin
        issue     = 1'b1;
        cmd.op    = CMD_PAN;
        phase_nxt = PH_PITCH_LO;
      end
      PH_PITCH_LO: begin
        low_nxt   = in_data_byte;
        phase_nxt = PH_PITCH_HI;
      end
      PH_PITCH_HI: begin
        issue     = 1'b1;
        cmd.op    = CMD_PITCH;
        cmd.data  = word;
        phase_nxt = PH_LAYER_LO;
      end
      default: begin
        low_nxt   = in_data_byte;
        phase_nxt = PH_TICK_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TICK_LO;
      version_r <= VERSION_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
      end
      if (cfg_valid) begin
        version_r <= cfg_format_version;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      low_r <= low_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nrsp_back.sv -----
// Back stage: carries out commands, keeps tick and layer counts, builds records.
// Depends on nrsp_pkg.
`default_nettype none

module nrsp_back #(
  parameter int TICK_BITS = nrsp_pkg::TICK_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_empty,
  input  wire nrsp_pkg::cmd_t cmd,
  output logic             cmd_pop,
  input  wire logic        rec_full,
  output logic             rec_push,
  output nrsp_pkg::rec_t   rec
);
  import nrsp_pkg::*;

  logic [TICK_BITS-1:0]            tick_r, tick_add;
  logic                            tick_neg_r;
  logic [LAYER_W-1:0]              layer_r, layer_add;
  logic                            layer_neg_r;
  logic [7:0]                      inst_r, key_r, vel_r, pan_r;
  logic [TICK_BITS:0]              tick_sum;
  logic [LAYER_W:0]                layer_sum;
  logic [TICK_BITS+TICK_OUT_W-1:0] tick_wide;
  logic                            emits, go, is_short;

  assign is_short = (cmd.op == CMD_KEY_SHORT);
  assign emits    = (cmd.op == CMD_END) || is_short || (cmd.op == CMD_PITCH);
  assign go       = !cmd_empty && (!emits || !rec_full);
  assign cmd_pop  = go;
  assign rec_push = go && emits;

  // Saturating accumulate; a count at minus one takes the jump less one
  assign tick_sum  = {1'b0, tick_r} + (TICK_BITS + 1)'(cmd.data);
  assign tick_add  = tick_neg_r ? TICK_BITS'(cmd.data - 16'd1) :
                     (tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0]);
  assign layer_sum = {1'b0, layer_r} + (LAYER_W + 1)'(cmd.data);
  assign layer_add = layer_neg_r ? LAYER_W'(cmd.data - 16'd1) :
                     (layer_sum[LAYER_W] ? '1 : layer_sum[LAYER_W-1:0]);

  assign tick_wide = {TICK_OUT_W'(0), tick_r};

  always_comb begin
    rec = '0;
    if (cmd.op == CMD_END) begin
      rec.kind = RECORD_END;
    end else begin
      rec.kind       = RECORD_NOTE;
      rec.tick       = tick_wide[TICK_OUT_W-1:0];
      rec.layer      = layer_r;
      rec.instrument = inst_r;
      if (is_short) begin
        rec.note_key = cmd.data[7:0];
        rec.velocity = VELOCITY_DEFAULT;
      end else begin
        rec.note_key = key_r;
        rec.velocity = vel_r;
        rec.panning  = {1'b0, pan_r} - PAN_BIAS;
        rec.pitch    = cmd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_neg_r  <= 1'b1;
      layer_neg_r <= 1'b1;
    end else if (go) begin
      case (cmd.op)
        CMD_END: begin
          tick_neg_r  <= 1'b1;
          layer_neg_r <= 1'b1;
        end
        CMD_TICK:      tick_neg_r  <= 1'b0;
        CMD_LAYER_CLR: layer_neg_r <= 1'b1;
        CMD_LAYER:     layer_neg_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      case (cmd.op)
        CMD_TICK:      tick_r  <= tick_add;
        CMD_LAYER:     layer_r <= layer_add;
        CMD_INSTR:     inst_r  <= cmd.data[7:0];
        CMD_KEY_SHORT: key_r   <= cmd.data[7:0];
        CMD_KEY_LONG:  key_r   <= cmd.data[7:0];
        CMD_VEL:       vel_r   <= cmd.data[7:0];
        CMD_PAN:       pan_r   <= cmd.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/note_record_stream_parser.sv -----
// Top level of the note record stream parser: front, command queue, back, result queue.
// Depends on nrsp_pkg, nrsp_fifo, nrsp_front and nrsp_back.
//
// The parser takes the note section of a song file one byte per item and
// returns one record per note plus an end record when a zero tick jump closes
// the section. It takes a byte every cycle while in_full is low: the front stage
// sequences the byte layout and turns each meaningful byte into a command, a
// two-entry command queue decouples it from the back stage, and the back stage
// retires one command per cycle, updating the saturating tick and layer counts
// and assembling records into a two-entry result queue. A record passes both
// queues after the byte that completes it is taken, reaches the out_ ports and
// stays there until popped; while the result queue is full the back stage
// holds and, once the command queue fills, in_full rises. The format version
// register (reset 4) is written through the cfg_ channel, which is always
// ready; write it only between sections while the parser is idle. The version
// is sampled when a note's key byte arrives: from 4 upwards velocity, panning
// and a little-endian signed pitch follow, below 4 the record carries velocity
// 100, panning 0 and pitch 0. Panning is the raw byte minus 100, signed.
// Ticks saturate at 2^TICK_BITS - 1 and are shown as their low 24 bits;
// layers saturate at 65535.
`default_nettype none

module note_record_stream_parser #(
  parameter int TICK_BITS   = nrsp_pkg::TICK_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = nrsp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [7:0]                        in_data_byte,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic                                   out_record_kind,
  output logic [nrsp_pkg::TICK_OUT_W-1:0]        out_tick,
  output logic [nrsp_pkg::LAYER_W-1:0]           out_layer,
  output logic [7:0]                             out_instrument,
  output logic [7:0]                             out_note_key,
  output logic [7:0]                             out_velocity,
  output logic signed [8:0]                      out_panning,
  output logic signed [15:0]                     out_pitch,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [7:0]                        cfg_format_version
);
  import nrsp_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int REC_W = $bits(rec_t);

  cmd_t             cmd_wr, cmd_rd;
  logic [CMD_W-1:0] cmd_rd_vec;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  rec_t             rec_wr, rec_rd;
  logic [REC_W-1:0] rec_rd_vec;
  logic             rec_push, rec_full;

  // Front: follow the byte layout, hold low bytes, sample the version
  nrsp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_format_version (cfg_format_version),
    .cmd_push           (cmd_push),
    .cmd                (cmd_wr),
    .cmd_full           (cmd_full)
  );

  // Command queue between the two stages
  nrsp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd_vec),
    .empty   (cmd_empty)
  );

  assign cmd_rd = cmd_t'(cmd_rd_vec);

  // Back: advance counts, build records
  nrsp_back #(
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .rec_full  (rec_full),
    .rec_push  (rec_push),
    .rec       (rec_wr)
  );

  // Result queue; its head drives the out_ ports
  nrsp_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_rec_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .wr_data (rec_wr),
    .full    (rec_full),
    .pop     (out_pop),
    .rd_data (rec_rd_vec),
    .empty   (out_empty)
  );

  assign rec_rd          = rec_t'(rec_rd_vec);
  assign out_record_kind = rec_rd.kind;
  assign out_tick        = rec_rd.tick;
  assign out_layer       = rec_rd.layer;
  assign out_instrument  = rec_rd.instrument;
  assign out_note_key    = rec_rd.note_key;
  assign out_velocity    = rec_rd.velocity;
  assign out_panning     = rec_rd.panning;
  assign out_pitch       = rec_rd.pitch;

endmodule

`default_nettype wire

// ----- hw/rtl/nrsp_chk.sv -----
// Port-level checker for the note record stream parser, bound to the top level.
// Sees only the top level ports; no package dependency.
`default_nettype none

module nrsp_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic               out_record_kind,
  input wire logic [23:0]        out_tick,
  input wire logic [15:0]        out_layer,
  input wire logic [7:0]         out_instrument,
  input wire logic [7:0]         out_note_key,
  input wire logic [7:0]         out_velocity,
  input wire logic signed [8:0]  out_panning,
  input wire logic signed [15:0] out_pitch
);

  // Reset drains both queues
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // An end record carries nothing but its kind
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_record_kind) |->
      (out_tick == 24'd0 && out_layer == 16'd0 && out_instrument == 8'd0 &&
       out_note_key == 8'd0 && out_velocity == 8'd0 && out_panning == 9'sd0 &&
       out_pitch == 16'sd0))
    else $error("end record with nonzero fields");

  // The input side fills only by taking bytes
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("in_full rose without a push");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_record_kind) && $stable(out_tick) &&
       $stable(out_layer) && $stable(out_pitch)))
    else $error("waiting result changed before pop");

endmodule

bind note_record_stream_parser nrsp_chk u_nrsp_chk (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for note_record_stream_parser: directed rows, then random note sections.
// Depends on nrsp_pkg and the parser RTL; expected records come from an inline byte-level predictor.

module testbench;
  import nrsp_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int TICK_MAX      = (1 << TICK_BITS_DEFAULT) - 1;
  localparam int LAYER_MAX     = 65535;
  // A record passes both queues after its last byte; allow for that and for waiting entries
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES   = 20;
  // Enough near-maximum tick jumps to pass 2^24 - 1 whatever the draw
  localparam int SAT_TICKS     = 260;
  localparam int CYCLE_LIMIT   = 600000;

  // Where the parser stands in the byte layout of the note section
  typedef enum logic [3:0] {
    P_TICK_LO, P_TICK_HI, P_LAYER_LO, P_LAYER_HI, P_INSTR,
    P_KEY, P_VEL, P_PAN, P_PITCH_LO, P_PITCH_HI
  } parse_phase_t;

  // Counts use -1 for "nothing yet", as the parser does after reset and after an end record
  typedef struct {
    parse_phase_t phase;
    int           tick_pos;
    int           layer_pos;
    logic [7:0]   lo_hold;
    logic [7:0]   instr;
    logic [7:0]   key;
    logic [7:0]   vel;
    logic [7:0]   pan;
  } parse_state_t;

  // One directed row: a byte item, or a version write made while the parser is idle
  typedef struct {
    logic       is_cfg;
    logic [7:0] value;
    logic       checked;
    rec_t       rec;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [7:0]        in_data_byte;
  logic              out_empty;
  logic              out_pop;
  logic              out_record_kind;
  logic [23:0]       out_tick;
  logic [15:0]       out_layer;
  logic [7:0]        out_instrument;
  logic [7:0]        out_note_key;
  logic [7:0]        out_velocity;
  logic signed [8:0] out_panning;
  logic signed [15:0] out_pitch;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_format_version;

  rec_t         pending_records[$];
  stim_row_t    dir_rows[$];
  parse_state_t model_state;
  parse_state_t plan_state;
  logic [7:0]   model_version;
  logic [7:0]   plan_version;
  logic         row_checked;
  rec_t         row_record;
  bit           stalls_on;
  int           stall_odds;
  int           errors = 0;
  int           notes_seen = 0;
  int           ends_seen = 0;
  int           bytes_sent = 0;
  int           versions_written = 0;
  int           cycle_cnt = 0;

  note_record_stream_parser uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_record_kind    (out_record_kind),
    .out_tick           (out_tick),
    .out_layer          (out_layer),
    .out_instrument     (out_instrument),
    .out_note_key       (out_note_key),
    .out_velocity       (out_velocity),
    .out_panning        (out_panning),
    .out_pitch          (out_pitch),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_format_version (cfg_format_version)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic void reset_parse(output parse_state_t st);
    st.phase     = P_TICK_LO;
    st.tick_pos  = -1;
    st.layer_pos = -1;
    st.lo_hold   = '0;
    st.instr     = '0;
    st.key       = '0;
    st.vel       = '0;
    st.pan       = '0;
  endfunction

  // Advance the parse by one byte; return 1 with the record when the byte completes one.
  // The version counts only at the key byte: that decides whether the long body follows.
  function automatic bit parse_byte(inout parse_state_t st, input logic [7:0] version,
                                    input logic [7:0] b, output rec_t rec);
    int jump;
    bit note_out;
    rec      = '0;
    note_out = 1'b0;
    jump     = int'({b, st.lo_hold});
    parse_byte = 1'b0;
    case (st.phase)
      P_TICK_HI: begin
        if (jump == 0) begin
          // zero tick jump: close the section, every field but the kind stays zero
          st.tick_pos  = -1;
          st.layer_pos = -1;
          st.phase     = P_TICK_LO;
          rec.kind     = RECORD_END;
          parse_byte   = 1'b1;
        end else begin
          st.tick_pos = (st.tick_pos + jump > TICK_MAX) ? TICK_MAX : st.tick_pos + jump;
          st.phase    = P_LAYER_LO;
        end
      end
      P_LAYER_LO: begin
        st.lo_hold = b;
        st.phase   = P_LAYER_HI;
      end
      P_LAYER_HI: begin
        if (jump == 0) begin
          // zero layer jump: the tick is done, layers count afresh
          st.layer_pos = -1;
          st.phase     = P_TICK_LO;
        end else begin
          st.layer_pos = (st.layer_pos + jump > LAYER_MAX) ? LAYER_MAX : st.layer_pos + jump;
          st.phase     = P_INSTR;
        end
      end
      P_INSTR: begin
        st.instr = b;
        st.phase = P_KEY;
      end
      P_KEY: begin
        st.key = b;
        if (version >= VERSION_EXT_MIN) begin
          st.phase = P_VEL;
        end else begin
          rec.velocity = VELOCITY_DEFAULT;
          note_out     = 1'b1;
          st.phase     = P_LAYER_LO;
        end
      end
      P_VEL: begin
        st.vel   = b;
        st.phase = P_PAN;
      end
      P_PAN: begin
        st.pan   = b;
        st.phase = P_PITCH_LO;
      end
      P_PITCH_LO: begin
        st.lo_hold = b;
        st.phase   = P_PITCH_HI;
      end
      P_PITCH_HI: begin
        rec.velocity = st.vel;
        rec.panning  = {1'b0, st.pan} - PAN_BIAS;
        rec.pitch    = {b, st.lo_hold};
        note_out     = 1'b1;
        st.phase     = P_LAYER_LO;
      end
      default: begin
        st.lo_hold = b;
        st.phase   = P_TICK_HI;
      end
    endcase
    if (note_out) begin
      rec.kind       = RECORD_NOTE;
      rec.tick       = st.tick_pos[23:0];
      rec.layer      = st.layer_pos[15:0];
      rec.instrument = st.instr;
      rec.note_key   = st.key;
      parse_byte     = 1'b1;
    end
  endfunction

  function automatic rec_t mk_note(input logic [23:0] tk, input logic [15:0] ly,
                                   input logic [7:0] ins, input logic [7:0] k,
                                   input logic [7:0] v, input logic signed [8:0] pn,
                                   input logic signed [15:0] pt);
    mk_note = '{kind: RECORD_NOTE, tick: tk, layer: ly, instrument: ins, note_key: k,
                velocity: v, panning: pn, pitch: pt};
  endfunction

  function automatic void add_row(input logic is_cfg, input logic [7:0] v,
                                  input logic checked, input rec_t rec);
    stim_row_t r;
    r.is_cfg  = is_cfg;
    r.value   = v;
    r.checked = checked;
    r.rec     = rec;
    dir_rows.push_back(r);
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic compare_record(input rec_t want, input rec_t got);
    if (got.kind !== want.kind)             report_field("record_kind", want.kind, got.kind);
    if (got.tick !== want.tick)             report_field("tick", want.tick, got.tick);
    if (got.layer !== want.layer)           report_field("layer", want.layer, got.layer);
    if (got.instrument !== want.instrument) report_field("instrument", want.instrument,
                                                         got.instrument);
    if (got.note_key !== want.note_key)     report_field("note_key", want.note_key, got.note_key);
    if (got.velocity !== want.velocity)     report_field("velocity", want.velocity, got.velocity);
    if (got.panning !== want.panning)       report_field("panning", $signed(want.panning),
                                                         $signed(got.panning));
    if (got.pitch !== want.pitch)           report_field("pitch", $signed(want.pitch),
                                                         $signed(got.pitch));
    if (want.kind == RECORD_END) ends_seen++;
    else notes_seen++;
  endtask

  // Everything the parser takes or hands over is seen here, at the rising edge.
  // Directed rows that carry a typed record use it in place of the predicted one.
  always @(posedge clk) begin
    rec_t predicted;
    rec_t seen;
    bit   made;
    if (rst_n) begin
      if (in_push && !in_full) begin
        made = parse_byte(model_state, model_version, in_data_byte, predicted);
        if (made) pending_records.push_back(row_checked ? row_record : predicted);
      end
      if (out_pop && !out_empty) begin
        seen = {out_record_kind, out_tick, out_layer, out_instrument, out_note_key,
                out_velocity, out_panning, out_pitch};
        if (pending_records.size() == 0) begin
          $display("%0t: record with nothing pending, kind %0d tick %0d layer %0d key %0d",
                   $time, out_record_kind, out_tick, out_layer, out_note_key);
          errors++;
        end else begin
          compare_record(pending_records.pop_front(), seen);
        end
      end
      if (cfg_valid && cfg_ready) model_version = cfg_format_version;
    end
  end

  // Offer one byte item, with a random hold-off first, and return at the falling edge
  // after it has been taken. Push stays high on return: a drain, or a hold-off in the next call, drops it.
  task automatic send_byte(input logic [7:0] b, input logic checked, input rec_t rec);
    rec_t unused;
    if (stalls_on && $urandom_range(1, 100) <= stall_odds) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_push      = 1'b1;
    in_data_byte = b;
    row_checked  = checked;
    row_record   = rec;
    @(posedge clk);
    while (in_full) @(posedge clk);
    // keep the generator's own view of the parse, so sections can be planned from it
    void'(parse_byte(plan_state, plan_version, b, unused));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic put_jump(input int j);
    put(j[7:0]);
    put(j[15:8]);
  endtask

  // Write the format version only once the parser has nothing left in flight
  task automatic write_version(input logic [7:0] v);
    in_push = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid          = 1'b1;
    cfg_format_version = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid    = 1'b0;
    plan_version = v;
    versions_written++;
  endtask

  // One note: nonzero layer jump, instrument, key and, for a long body, four more bytes
  task automatic put_note();
    put_jump(($urandom_range(0, 15) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 8));
    put(8'($urandom_range(0, 255)));
    put(8'($urandom_range(0, 255)));
    if (plan_version >= VERSION_EXT_MIN) repeat (4) put(8'($urandom_range(0, 255)));
  endtask

  // A well-formed section: a few ticks, each with some notes and a closing zero jump
  task automatic put_section();
    repeat ($urandom_range(1, 4)) begin
      put_jump(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 64));
      repeat ($urandom_range(0, 4)) put_note();
      put_jump(0);
    end
    put_jump(0);
  endtask

  // Feed bytes until the parse is back at a tick jump; zero bytes in the layer
  // phases close the tick, anything else is random content
  task automatic resync();
    while (plan_state.phase != P_TICK_LO)
      put((plan_state.phase == P_LAYER_LO || plan_state.phase == P_LAYER_HI) ?
          8'h00 : 8'($urandom_range(0, 255)));
  endtask

  // Result side: pop freely, with random stall bursts while stalls are on
  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(1, 100) <= stall_odds) begin
        out_pop = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_pop = 1'b1;
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d records pending", cycle_cnt,
             pending_records.size());
    $display("[note_record_stream_parser] ERROR");
    $finish;
  end

  initial begin
    rec_t       end_rec;
    logic [7:0] v;
    int         phase_start;
    int         roll;

    rst_n              = 1'b0;
    in_push            = 1'b0;
    in_data_byte       = '0;
    cfg_valid          = 1'b0;
    cfg_format_version = '0;
    row_checked        = 1'b0;
    row_record         = '0;
    stalls_on          = 1'b1;
    stall_odds         = 10;
    model_version      = VERSION_RESET;
    plan_version       = VERSION_RESET;
    reset_parse(model_state);
    reset_parse(plan_state);

    end_rec      = '0;
    end_rec.kind = RECORD_END;

    // Directed rows, starting from the reset version of 4 (long note bodies)
    // tick jump 1 -> tick 0; layer jump 2 -> layer 1
    add_row(0, 8'h01, 0, '0);  add_row(0, 8'h00, 0, '0);
    add_row(0, 8'h02, 0, '0);  add_row(0, 8'h00, 0, '0);
    // all-zero body with pitch at its most negative: panning bottoms out at -100
    add_row(0, 8'h00, 0, '0);  add_row(0, 8'h00, 0, '0);  add_row(0, 8'h00, 0, '0);
    add_row(0, 8'h00, 0, '0);  add_row(0, 8'h00, 0, '0);
    add_row(0, 8'h80, 1, mk_note(0, 1, 8'h00, 8'h00, 8'h00, -100, -32768));
    // largest layer jump pushes the layer past its maximum; all-ones body, pitch at its largest
    add_row(0, 8'hff, 0, '0);  add_row(0, 8'hff, 0, '0);
    add_row(0, 8'hff, 0, '0);  add_row(0, 8'hff, 0, '0);  add_row(0, 8'hff, 0, '0);
    add_row(0, 8'hff, 0, '0);  add_row(0, 8'hff, 0, '0);
    add_row(0, 8'h7f, 1, mk_note(0, 65535, 8'hff, 8'hff, 8'hff, 155, 32767));
    // drop to a short-body version, then raise it again between instrument and key:
    // the key byte sees the new value, so the long body follows
    add_row(1, VERSION_EXT_MIN - 8'd1, 0, '0);
    add_row(0, 8'h01, 0, '0);  add_row(0, 8'h00, 0, '0);
    add_row(0, 8'h07, 0, '0);
    add_row(1, 8'hff, 0, '0);
    add_row(0, 8'h09, 0, '0);  add_row(0, 8'h11, 0, '0);  add_row(0, 8'hc8, 0, '0);
    add_row(0, 8'h34, 0, '0);
    add_row(0, 8'h12, 1, mk_note(0, 65535, 8'h07, 8'h09, 8'h11, 100, 16'h1234));
    // close the tick, then close the section
    add_row(0, 8'h00, 0, '0);  add_row(0, 8'h00, 0, '0);
    add_row(0, 8'h00, 0, '0);  add_row(0, 8'h00, 1, end_rec);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_version(dir_rows[i].value);
      else send_byte(dir_rows[i].value, dir_rows[i].checked, dir_rows[i].rec);
    end

    // Random phases: each picks a version and an idling rate, then streams sections, noise and cut-off notes.
    // The last two phases run with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        0:       v = 8'h00;
        1:       v = 8'hff;
        2:       v = VERSION_EXT_MIN - 8'd1;
        3:       v = VERSION_EXT_MIN;
        default: v = 8'($urandom_range(0, 255));
      endcase
      stalls_on = (p < RANDOM_PHASES - 2);
      case ($urandom_range(0, 3))
        0:       stall_odds = 0;
        1:       stall_odds = 4;
        2:       stall_odds = 15;
        default: stall_odds = 40;
      endcase
      write_version(v);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
          put_section();
        end else if (roll == 8) begin
          // noise: raw bytes wherever they land in the layout
          repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
          resync();
        end else begin
          // broken sequence: a note cut off after its instrument byte
          put_jump($urandom_range(1, 64));
          put_jump($urandom_range(1, 8));
          put(8'($urandom_range(0, 255)));
          resync();
        end
      end
      // mid-run: march the tick count into saturation with large jumps
      if (p == RANDOM_PHASES / 2) begin
        repeat (SAT_TICKS) begin
          put_jump($urandom_range(16'hff00, 16'hffff));
          if ($urandom_range(0, 39) == 0) put_note();
          put_jump(0);
        end
        // one more tick, so at least one note shows the count pinned at its maximum
        put_jump(1);
        put_note();
        put_jump(0);
        put_jump(0);
      end
    end

    // hold push low, let every record drain, then give the pipeline time to show strays
    in_push = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("Streamed %0d bytes under %0d version settings,", bytes_sent, versions_written);
    $display("checked %0d note records and %0d end records.", notes_seen, ends_seen);
    if (errors == 0) begin
      $display("[note_record_stream_parser] OK");
    end else begin
      $display("[note_record_stream_parser] ERROR");
    end
    $finish;
  end

endmodule

// ----- note_record_stream_parser.f -----
hw/rtl/nrsp_pkg.sv
hw/rtl/nrsp_fifo.sv
hw/rtl/nrsp_front.sv
hw/rtl/nrsp_back.sv
hw/rtl/note_record_stream_parser.sv
hw/rtl/nrsp_chk.sv
sim/testbench.sv
